// ===== hw/rtl/zot_pkg.sv =====
// ----------------------------------------------------------------------------
// zot_pkg
// constants shared by the zone occupancy tracker
// ----------------------------------------------------------------------------
package zot_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int CAL_MAX    = 1023;
  localparam int CAL_MIN    = 3;
  localparam int PCT_DIV    = 100;

  localparam int DW  = 16;   // distance width
  localparam int CW  = 10;   // calibration count width
  localparam int SW  = 26;   // calibration sum width
  localparam int QW  = 42;   // calibration sum of squares width
  localparam int WIW = $clog2(WINDOW_MAX);

  localparam logic [1:0] REG_LOW_PCT  = 2'd0;
  localparam logic [1:0] REG_HIGH_PCT = 2'd1;
  localparam logic [1:0] REG_ALPHA    = 2'd2;
  localparam logic [1:0] REG_WIN_LEN  = 2'd3;

  localparam logic [1:0] CAL_NONE    = 2'd0;
  localparam logic [1:0] CAL_OK      = 2'd1;
  localparam logic [1:0] CAL_FEW     = 2'd2;
  localparam logic [1:0] CAL_BAD_THR = 2'd3;

endpackage

// ===== hw/rtl/zone_occupancy_tracker.sv =====
// ----------------------------------------------------------------------------
// zone_occupancy_tracker
// distance window minimum, occupancy flag, idle baseline adaptation and
// calibration, built on bit-serial multiply, divide and square root units
// ----------------------------------------------------------------------------
// usage
//   in_*  : one sample item (kind, valid_req, distance, last) per handshake
//   out_* : one result item per input item, held in an output register
//   cfg_* : register writes (index 0..3), always ready, only while idle
// sequencing, one item at a time, from acceptance to its result load
//   invalid measurement: the result load; invalid calibration item: the
//   calibration check and the result load
//   valid measurement: the minimum scan over the window samples and the
//   adaptation check; baseline adaptation adds a 16-step shift-add
//   multiplier, then per threshold a 16-step multiply and a 42-step
//   restoring divide; valid calibration sample: the minimum scan and a
//   16-step square; calibration end adds two 42-step divisions, a 16-step
//   square, a 16-step square root and both thresholds
// reset clears window, baseline, thresholds and accumulators; registers
// take their default values
// a stalled result holds; the next item is taken meanwhile and waits only
// at its own result load
// ----------------------------------------------------------------------------
module zone_occupancy_tracker import zot_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic          in_valid_req,
  input  logic [15:0]   in_distance,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_occupied,
  output logic [15:0]   out_window_min,
  output logic [15:0]   out_idle_level,
  output logic [15:0]   out_thr_low,
  output logic [15:0]   out_thr_high,
  output logic [1:0]    out_cal_status,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_MIN    = 13'b0000000000010,
    S_ADCHK  = 13'b0000000000100,
    S_AMUL   = 13'b0000000001000,
    S_SQ     = 13'b0000000010000,
    S_CALCHK = 13'b0000000100000,
    S_DMEAN  = 13'b0000001000000,
    S_DMSQ   = 13'b0000010000000,
    S_MSQ    = 13'b0000100000000,
    S_SQRT   = 13'b0001000000000,
    S_TMUL   = 13'b0010000000000,
    S_TDIV   = 13'b0100000000000,
    S_OUTW   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  low_pct_r, low_pct_nxt, high_pct_r, high_pct_nxt;
  logic [15:0] alpha_r, alpha_nxt;
  logic [4:0]  win_len_r, win_len_nxt;

  logic [DW-1:0] win_r [WINDOW_MAX];
  logic [DW-1:0] win_nxt [WINDOW_MAX];
  logic [4:0]    win_fill_r, win_fill_nxt;
  logic [DW-1:0] min_r, min_nxt, mn_r, mn_nxt;
  logic [DW-1:0] idle_r, idle_nxt, thr_lo_r, thr_lo_nxt, thr_hi_r, thr_hi_nxt;
  logic [CW-1:0] cal_cnt_r, cal_cnt_nxt;
  logic [SW-1:0] cal_sum_r, cal_sum_nxt;
  logic [QW-1:0] cal_sq_r, cal_sq_nxt;
  logic [1:0]    status_r, status_nxt;

  logic          kind_r, kind_nxt, last_r, last_nxt;
  logic [DW-1:0] dist_r, dist_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          phase_hi_r, phase_hi_nxt;
  logic          up_r, up_nxt;
  logic [DW-1:0] mean_r, mean_nxt;
  logic [31:0]   msq_r, msq_nxt;

  logic [31:0]   mul_acc_r, mul_acc_nxt, mul_a_r, mul_a_nxt;
  logic [15:0]   mul_b_r, mul_b_nxt;
  logic [31:0]   mul_add;

  logic [QW-1:0] div_q_r, div_q_nxt;
  logic [CW-1:0] div_rem_r, div_rem_nxt, div_dvs_r, div_dvs_nxt;
  logic [CW:0]   div_t;
  logic          div_ge;
  logic [QW-1:0] div_quo;

  logic [31:0]   sq_v_r, sq_v_nxt;
  logic [17:0]   sq_rem_r, sq_rem_nxt;
  logic [15:0]   sq_root_r, sq_root_nxt;
  logic [19:0]   sq_t, sq_trial;
  logic          sq_ge;

  logic          out_valid_r, out_valid_nxt, out_occ_r, out_occ_nxt;
  logic [DW-1:0] out_min_r, out_min_nxt, out_idle_r, out_idle_nxt;
  logic [DW-1:0] out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  logic [4:0]    len_eff, scan_n;
  logic [DW-1:0] win_rd, mn_cur;
  logic [DW-1:0] diff;
  logic [18:0]   diff5;
  logic [32:0]   up_round;
  logic [DW-1:0] new_idle;
  logic [15:0]   sd;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign mul_add  = mul_acc_r + (mul_b_r[0] ? mul_a_r : 32'd0);
  assign div_t    = {div_rem_r, div_q_r[QW-1]};
  assign div_ge   = (div_t >= {1'b0, div_dvs_r});
  assign div_quo  = {div_q_r[QW-2:0], div_ge};
  assign sq_t     = {sq_rem_r, sq_v_r[31:30]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);
  assign sd       = {sq_root_r[14:0], sq_ge};

  assign len_eff  = (win_len_r == 5'd0) ? 5'd1 :
                    (win_len_r > 5'(WINDOW_MAX)) ? 5'(WINDOW_MAX) : win_len_r;
  assign scan_n   = (len_eff < win_fill_r) ? len_eff : win_fill_r;
  assign win_rd   = win_r[cnt_r[WIW-1:0]];
  assign mn_cur   = (cnt_r == 6'd0) ? win_rd : ((win_rd < mn_r) ? win_rd : mn_r);
  assign diff     = (dist_r > idle_r) ? (dist_r - idle_r) : (idle_r - dist_r);
  assign diff5    = {1'b0, diff, 2'b00} + {3'b000, diff};
  assign up_round = {1'b0, mul_add} + 33'd65535;

  always_comb begin
    state_nxt    = state_r;
    low_pct_nxt  = low_pct_r;
    high_pct_nxt = high_pct_r;
    alpha_nxt    = alpha_r;
    win_len_nxt  = win_len_r;
    win_nxt      = win_r;
    win_fill_nxt = win_fill_r;
    min_nxt      = min_r;
    mn_nxt       = mn_r;
    idle_nxt     = idle_r;
    thr_lo_nxt   = thr_lo_r;
    thr_hi_nxt   = thr_hi_r;
    cal_cnt_nxt  = cal_cnt_r;
    cal_sum_nxt  = cal_sum_r;
    cal_sq_nxt   = cal_sq_r;
    status_nxt   = status_r;
    kind_nxt     = kind_r;
    last_nxt     = last_r;
    dist_nxt     = dist_r;
    cnt_nxt      = cnt_r + 6'd1;
    phase_hi_nxt = phase_hi_r;
    up_nxt       = up_r;
    mean_nxt     = mean_r;
    msq_nxt      = msq_r;
    mul_acc_nxt  = mul_add;
    mul_a_nxt    = {mul_a_r[30:0], 1'b0};
    mul_b_nxt    = {1'b0, mul_b_r[15:1]};
    div_q_nxt    = div_quo;
    div_rem_nxt  = div_ge ? 10'(div_t - {1'b0, div_dvs_r}) : div_t[CW-1:0];
    div_dvs_nxt  = div_dvs_r;
    sq_v_nxt     = {sq_v_r[29:0], 2'b00};
    sq_rem_nxt   = sq_ge ? 18'(sq_t - sq_trial) : sq_t[17:0];
    sq_root_nxt  = sd;
    new_idle     = idle_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    out_occ_nxt  = out_occ_r;
    out_min_nxt  = out_min_r;
    out_idle_nxt = out_idle_r;
    out_lo_nxt   = out_lo_r;
    out_hi_nxt   = out_hi_r;
    out_st_nxt   = out_st_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_PCT:  low_pct_nxt  = cfg_data[7:0];
        REG_HIGH_PCT: high_pct_nxt = cfg_data[7:0];
        REG_ALPHA:    alpha_nxt    = cfg_data;
        REG_WIN_LEN:  win_len_nxt  = cfg_data[4:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        cnt_nxt = 6'd0;
        if (in_valid) begin
          kind_nxt = in_kind;
          last_nxt = in_last;
          dist_nxt = in_distance;
          if (in_valid_req) begin
            win_nxt[0] = in_distance;
            for (int i = 1; i < WINDOW_MAX; i++) win_nxt[i] = win_r[i-1];
            if (win_fill_r < 5'(WINDOW_MAX)) win_fill_nxt = win_fill_r + 5'd1;
            state_nxt = S_MIN;
          end else if (in_kind) begin
            state_nxt = S_CALCHK;
          end else begin
            state_nxt = S_OUTW;
          end
        end
      end
      S_MIN: begin
        mn_nxt = mn_cur;
        if (cnt_r == {1'b0, scan_n - 5'd1}) begin
          min_nxt = mn_cur;
          if (!kind_r) begin
            state_nxt = S_ADCHK;
          end else if (cal_cnt_r < 10'(CAL_MAX)) begin
            cnt_nxt   = 6'd0;
            mul_acc_nxt = 32'd0;
            mul_a_nxt = {16'd0, dist_r};
            mul_b_nxt = dist_r;
            state_nxt = S_SQ;
          end else begin
            state_nxt = S_CALCHK;
          end
        end
      end
      S_ADCHK: begin
        cnt_nxt     = 6'd0;
        mul_acc_nxt = 32'd0;
        mul_a_nxt   = {16'd0, alpha_r};
        mul_b_nxt   = diff;
        up_nxt      = (dist_r >= idle_r);
        if (dist_r > thr_hi_r && dist_r != 16'd0 && diff5 <= {3'b000, idle_r})
          state_nxt = S_AMUL;
        else
          state_nxt = S_OUTW;
      end
      S_AMUL: begin
        if (cnt_r == 6'd15) begin
          new_idle    = up_r ? (idle_r + mul_add[31:16]) : (idle_r - up_round[31:16]);
          idle_nxt    = new_idle;
          cnt_nxt     = 6'd0;
          mul_acc_nxt = 32'd0;
          mul_a_nxt   = {16'd0, new_idle};
          mul_b_nxt   = {8'd0, high_pct_r};
          phase_hi_nxt = 1'b1;
          state_nxt   = S_TMUL;
        end
      end
      S_SQ: begin
        if (cnt_r == 6'd15) begin
          cal_sq_nxt  = cal_sq_r + {10'd0, mul_add};
          cal_sum_nxt = cal_sum_r + {10'd0, dist_r};
          cal_cnt_nxt = cal_cnt_r + 10'd1;
          state_nxt   = S_CALCHK;
        end
      end
      S_CALCHK: begin
        cnt_nxt     = 6'd0;
        div_q_nxt   = {16'd0, cal_sum_r};
        div_rem_nxt = '0;
        div_dvs_nxt = cal_cnt_r;
        if (kind_r && last_r) begin
          if (cal_cnt_r < 10'(CAL_MIN)) begin
            status_nxt  = CAL_FEW;
            cal_cnt_nxt = '0;
            cal_sum_nxt = '0;
            cal_sq_nxt  = '0;
            state_nxt   = S_OUTW;
          end else begin
            state_nxt = S_DMEAN;
          end
        end else begin
          state_nxt = S_OUTW;
        end
      end
      S_DMEAN: begin
        if (cnt_r == 6'(QW-1)) begin
          mean_nxt    = div_quo[15:0];
          cnt_nxt     = 6'd0;
          div_q_nxt   = cal_sq_r;
          div_rem_nxt = '0;
          state_nxt   = S_DMSQ;
        end
      end
      S_DMSQ: begin
        if (cnt_r == 6'(QW-1)) begin
          msq_nxt     = div_quo[31:0];
          cnt_nxt     = 6'd0;
          mul_acc_nxt = 32'd0;
          mul_a_nxt   = {16'd0, mean_r};
          mul_b_nxt   = mean_r;
          state_nxt   = S_MSQ;
        end
      end
      S_MSQ: begin
        if (cnt_r == 6'd15) begin
          cnt_nxt     = 6'd0;
          sq_v_nxt    = (msq_r > mul_add) ? (msq_r - mul_add) : 32'd0;
          sq_rem_nxt  = '0;
          sq_root_nxt = '0;
          state_nxt   = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == 6'd15) begin
          new_idle    = (mean_r > sd) ? (mean_r - sd) : 16'd0;
          idle_nxt    = new_idle;
          cal_cnt_nxt = '0;
          cal_sum_nxt = '0;
          cal_sq_nxt  = '0;
          cnt_nxt     = 6'd0;
          mul_acc_nxt = 32'd0;
          mul_a_nxt   = {16'd0, new_idle};
          mul_b_nxt   = {8'd0, high_pct_r};
          phase_hi_nxt = 1'b1;
          state_nxt   = S_TMUL;
        end
      end
      S_TMUL: begin
        if (cnt_r == 6'd15) begin
          cnt_nxt     = 6'd0;
          div_q_nxt   = {10'd0, mul_add};
          div_rem_nxt = '0;
          div_dvs_nxt = 10'(PCT_DIV);
          state_nxt   = S_TDIV;
        end
      end
      S_TDIV: begin
        if (cnt_r == 6'(QW-1)) begin
          cnt_nxt = 6'd0;
          if (phase_hi_r) begin
            thr_hi_nxt   = div_quo[15:0];
            phase_hi_nxt = 1'b0;
            mul_acc_nxt  = 32'd0;
            mul_a_nxt    = {16'd0, idle_r};
            mul_b_nxt    = {8'd0, low_pct_r};
            state_nxt    = S_TMUL;
          end else begin
            thr_lo_nxt = div_quo[15:0];
            if (kind_r)
              status_nxt = (idle_r == 16'd0 || thr_hi_r <= div_quo[15:0]) ?
                           CAL_BAD_THR : CAL_OK;
            state_nxt = S_OUTW;
          end
        end
      end
      S_OUTW: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_occ_nxt   = (min_r < thr_hi_r) && (min_r > thr_lo_r);
          out_min_nxt   = min_r;
          out_idle_nxt  = idle_r;
          out_lo_nxt    = thr_lo_r;
          out_hi_nxt    = thr_hi_r;
          out_st_nxt    = status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_pct_r   <= 8'd0;
      high_pct_r  <= 8'd80;
      alpha_r     <= 16'd0;
      win_len_r   <= 5'd1;
      for (int i = 0; i < WINDOW_MAX; i++) win_r[i] <= '0;
      win_fill_r  <= '0;
      min_r       <= '0;
      idle_r      <= '0;
      thr_lo_r    <= '0;
      thr_hi_r    <= '0;
      cal_cnt_r   <= '0;
      cal_sum_r   <= '0;
      cal_sq_r    <= '0;
      status_r    <= CAL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_pct_r   <= low_pct_nxt;
      high_pct_r  <= high_pct_nxt;
      alpha_r     <= alpha_nxt;
      win_len_r   <= win_len_nxt;
      win_r       <= win_nxt;
      win_fill_r  <= win_fill_nxt;
      min_r       <= min_nxt;
      idle_r      <= idle_nxt;
      thr_lo_r    <= thr_lo_nxt;
      thr_hi_r    <= thr_hi_nxt;
      cal_cnt_r   <= cal_cnt_nxt;
      cal_sum_r   <= cal_sum_nxt;
      cal_sq_r    <= cal_sq_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mn_r       <= mn_nxt;
    kind_r     <= kind_nxt;
    last_r     <= last_nxt;
    dist_r     <= dist_nxt;
    cnt_r      <= cnt_nxt;
    phase_hi_r <= phase_hi_nxt;
    up_r       <= up_nxt;
    mean_r     <= mean_nxt;
    msq_r      <= msq_nxt;
    mul_acc_r  <= mul_acc_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_dvs_r  <= div_dvs_nxt;
    sq_v_r     <= sq_v_nxt;
    sq_rem_r   <= sq_rem_nxt;
    sq_root_r  <= sq_root_nxt;
    out_occ_r  <= out_occ_nxt;
    out_min_r  <= out_min_nxt;
    out_idle_r <= out_idle_nxt;
    out_lo_r   <= out_lo_nxt;
    out_hi_r   <= out_hi_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_occupied   = out_occ_r;
  assign out_window_min = out_min_r;
  assign out_idle_level = out_idle_r;
  assign out_thr_low    = out_lo_r;
  assign out_thr_high   = out_hi_r;
  assign out_cal_status = out_st_r;

`ifndef NO_ASSERTIONS
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    win_fill_r <= 5'(WINDOW_MAX))
    else $error("window fill above maximum");

  a_cal_max: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= 10'(CAL_MAX))
    else $error("calibration count above maximum");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUTW && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");

  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_valid_req) |=> (win_r[0] == $past(in_distance)))
    else $error("sample not pushed into window");
`endif

endmodule

// ===== bench/zot_checker.sv =====
// ----------------------------------------------------------------------------
// zot_checker
// predicts each result item of the zone occupancy tracker from the accepted
// sample items and register writes, and compares it field by field
// ----------------------------------------------------------------------------
module zot_checker import zot_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic        in_valid_req,
  input  logic [15:0] in_distance,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_occupied,
  input  logic [15:0] out_window_min,
  input  logic [15:0] out_idle_level,
  input  logic [15:0] out_thr_low,
  input  logic [15:0] out_thr_high,
  input  logic [1:0]  out_cal_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        occupied;
    logic [15:0] window_min;
    logic [15:0] idle_level;
    logic [15:0] thr_low;
    logic [15:0] thr_high;
    logic [1:0]  cal_status;
  } occ_result_t;

  occ_result_t expected_q[$];

  logic [7:0]  low_pct, high_pct;
  logic [15:0] alpha;
  logic [4:0]  win_len;
  logic [15:0] win [WINDOW_MAX];
  int          fill;
  logic [15:0] min_dist, idle, thr_lo, thr_hi;
  logic [9:0]  n_cal;
  logic [63:0] sum_d, sum_sq;
  logic [1:0]  cal_st;

  assign pending = expected_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic update_thresholds();
    logic [31:0] p;
    p = 32'(idle) * high_pct;
    thr_hi = 16'(p / 100);
    p = 32'(idle) * low_pct;
    thr_lo = 16'(p / 100);
  endtask

  task automatic predict_occupancy(logic kind, logic vreq, logic [15:0] d, logic lst);
    int n;
    logic [15:0] m, diff;
    logic [63:0] acc, mean, msq, var_v, sd;
    occ_result_t r;
    if (vreq) begin
      for (int i = WINDOW_MAX - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = d;
      if (fill < WINDOW_MAX) fill++;
      n = (win_len == 0) ? 1 : (win_len > WINDOW_MAX) ? WINDOW_MAX : win_len;
      if (n > fill) n = fill;
      m = win[0];
      for (int i = 1; i < n; i++) if (win[i] < m) m = win[i];
      min_dist = m;
      if (!kind) begin
        diff = (d > idle) ? d - idle : idle - d;
        if (d > thr_hi && d != 0 && diff <= idle / 5) begin
          acc = 64'(17'd65536 - alpha) * idle + 64'(alpha) * d;
          idle = 16'(acc >> 16);
          update_thresholds();
        end
      end else if (n_cal < CAL_MAX) begin
        n_cal++;
        sum_d += d;
        sum_sq += 64'(d) * d;
      end
    end
    if (kind && lst) begin
      if (n_cal < CAL_MIN) begin
        cal_st = CAL_FEW;
      end else begin
        mean = sum_d / n_cal;
        msq = sum_sq / n_cal;
        var_v = (msq > mean * mean) ? msq - mean * mean : 0;
        sd = int_sqrt(var_v);
        idle = (mean > sd) ? 16'(mean - sd) : 16'd0;
        update_thresholds();
        cal_st = (idle == 0 || thr_hi <= thr_lo) ? CAL_BAD_THR : CAL_OK;
      end
      n_cal = 0;
      sum_d = 0;
      sum_sq = 0;
    end
    r.occupied = (min_dist < thr_hi) && (min_dist > thr_lo);
    r.window_min = min_dist;
    r.idle_level = idle;
    r.thr_low = thr_lo;
    r.thr_high = thr_hi;
    r.cal_status = cal_st;
    expected_q.insert(expected_q.size(), r);
  endtask

  always @(posedge clk) begin
    occ_result_t e, a;
    if (!rst_n) begin
      low_pct <= 0; high_pct <= 80; alpha <= 0; win_len <= 1;
      for (int i = 0; i < WINDOW_MAX; i++) win[i] = 0;
      fill = 0; min_dist = 0; idle = 0; thr_lo = 0; thr_hi = 0;
      n_cal = 0; sum_d = 0; sum_sq = 0; cal_st = CAL_NONE;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_PCT:  low_pct <= cfg_data[7:0];
          REG_HIGH_PCT: high_pct <= cfg_data[7:0];
          REG_ALPHA:    alpha <= cfg_data;
          REG_WIN_LEN:  win_len <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_occupancy(in_kind, in_valid_req, in_distance, in_last);
      if (out_valid && !out_stall) begin
        a = '{out_occupied, out_window_min, out_idle_level, out_thr_low, out_thr_high,
              out_cal_status};
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item %p", a);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== a) begin
            if (errors < 10) $display("mismatch: expected %p actual %p", e, a);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_zone_occupancy_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_zone_occupancy_tracker
// drives directed and random sample items and register writes into the
// tracker under random idling and a long output hold-off; a checker beside
// the block predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_zone_occupancy_tracker import zot_pkg::*;;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_kind, in_valid_req, in_last;
  logic [15:0] in_distance;
  logic        out_valid, out_stall, out_occupied;
  logic [15:0] out_window_min, out_idle_level, out_thr_low, out_thr_high;
  logic [1:0]  out_cal_status;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors, pending;
  int          hold_cycles, hold_req, hold_ack;
  bit          no_idle;
  logic [15:0] base_dist;

  zone_occupancy_tracker dut (.*);
  zot_checker chk (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 34);
    end
  end

  task automatic send_item(logic k, logic v, logic [15:0] d, logic l);
    if (!no_idle) while ($urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_kind <= k; in_valid_req <= v; in_distance <= d; in_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    stop_input();
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic near_idle_item();
    int span;
    span = base_dist / 5 + 1;
    case ($urandom_range(9))
      0: send_item(1'b0, 1'b0, 16'($urandom), 1'($urandom));
      1, 2: send_item(1'b0, 1'b1, 16'($urandom), 1'($urandom));
      default: send_item(1'b0, 1'b1,
                 16'(int'(base_dist) + $urandom_range(2 * span) - span), 1'($urandom));
    endcase
  endtask

  task automatic calibration_run(int n);
    logic [15:0] c;
    c = 16'($urandom_range(200, 60000));
    base_dist = c;
    for (int i = 0; i < n; i++)
      send_item(1'b1, $urandom_range(9) != 0, 16'(int'(c) + $urandom_range(400) - 200),
                i == n - 1);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 0; in_kind = 0; in_valid_req = 0; in_distance = 0;
    in_last = 0; cfg_valid = 0; cfg_index = REG_LOW_PCT; cfg_data = 0;
    hold_req = 0; no_idle = 0; base_dist = 1000;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed
    send_item(1'b0, 1'b1, 16'hFFFF, 1'b1);
    send_item(1'b0, 1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 1'b0, 16'h1234, 1'b0);
    send_item(1'b1, 1'b1, 16'd500, 1'b1);
    send_item(1'b1, 1'b0, 16'd0, 1'b1);
    send_item(1'b1, 1'b1, 16'hFFFF, 1'b0);
    send_item(1'b1, 1'b1, 16'hFFFF, 1'b0);
    send_item(1'b1, 1'b1, 16'hFFFF, 1'b1);
    send_item(1'b1, 1'b1, 16'd0, 1'b0);
    send_item(1'b1, 1'b1, 16'd0, 1'b0);
    send_item(1'b1, 1'b1, 16'hFFFF, 1'b0);
    send_item(1'b1, 1'b1, 16'd0, 1'b1);
    drain();
    write_reg(REG_LOW_PCT, 16'd255);
    write_reg(REG_HIGH_PCT, 16'd255);
    write_reg(REG_ALPHA, 16'hFFFF);
    write_reg(REG_WIN_LEN, 16'd0);
    calibration_run(4);
    send_item(1'b0, 1'b1, base_dist, 1'b0);
    drain();
    write_reg(REG_LOW_PCT, 16'd30);
    write_reg(REG_HIGH_PCT, 16'd90);
    write_reg(REG_WIN_LEN, 16'd31);
    calibration_run(5);
    for (int i = 0; i < 6; i++) near_idle_item();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(REG_LOW_PCT, (ph % 4 == 0) ? 16'd0 : 16'($urandom_range(10, 60)));
      write_reg(REG_HIGH_PCT, (ph % 5 == 0) ? 16'd255 : 16'($urandom_range(60, 100)));
      write_reg(REG_ALPHA, (ph % 3 == 0) ? 16'd0 : 16'($urandom));
      write_reg(REG_WIN_LEN, 16'($urandom_range(31)));
      no_idle = (ph == 5);
      if (ph == 3) hold_req = hold_req + 1;
      calibration_run($urandom_range(ph == 2 ? 1 : 3, 12));
      for (int i = 0; i < 75; i++) begin
        if ($urandom_range(29) == 0) calibration_run($urandom_range(2, 8));
        else near_idle_item();
      end
      if (ph == 7) begin
        stop_input();
        while (pending != 0) @(negedge clk);
      end
    end
    no_idle = 0;
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/zot_pkg.sv
hw/rtl/zone_occupancy_tracker.sv
bench/zot_checker.sv
bench/tb_zone_occupancy_tracker.sv
